### sv/depth_roi_to_point_macros.svh
// Assertion macros used by the depth-to-point back end.
`ifndef DEPTH_ROI_TO_POINT_MACROS_SVH
`define DEPTH_ROI_TO_POINT_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define DR2P_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define DR2P_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

### sv/dr2p_pkg.sv
// Types and constants shared by the depth-to-point unprojection block.
package dr2p_pkg;

  localparam int MAX_DIM      = 4096;
  localparam int MAX_DEPTH_MM = 2500;

  localparam int DIM_W      = 12;
  localparam int GAIN_W     = 16;
  localparam int DEPTH_W    = 16;
  localparam int COORD_W    = 16;
  localparam int Z_W        = 12;
  localparam int CFG_DATA_W = 16;
  localparam int REG_IDX_W  = 3;
  localparam int FRAC_W     = 16;

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int CMP_W = (CNT_W > DIM_W) ? CNT_W : DIM_W;

  localparam int P1_W = CMP_W + GAIN_W;
  localparam int P2_W = P1_W + DEPTH_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_ROI_COL_LO   = 3'd2,
    REG_ROI_COL_HI   = 3'd3,
    REG_ROI_ROW_LO   = 3'd4,
    REG_ROI_ROW_HI   = 3'd5,
    REG_X_GAIN       = 3'd6,
    REG_Y_GAIN       = 3'd7
  } reg_idx_t;

  // Frame geometry seen by the front end
  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [DIM_W-1:0] roi_col_lo;
    logic [DIM_W-1:0] roi_col_hi;
    logic [DIM_W-1:0] roi_row_lo;
    logic [DIM_W-1:0] roi_row_hi;
  } geom_t;

  // One classified pixel, queued between front and back
  typedef struct packed {
    logic               keep;
    logic               neg_x;
    logic [CMP_W-1:0]   mag_x;
    logic               neg_y;
    logic [CMP_W-1:0]   mag_y;
    logic [DEPTH_W-1:0] depth;
    logic               frame_end;
  } pix_t;

endpackage

### sv/dr2p_front.sv
// Front end: pixel counters, region and depth check, centre offsets.
module dr2p_front (
  input  logic                         clk,
  input  logic                         rst,
  input  dr2p_pkg::geom_t              geom,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dr2p_pkg::DEPTH_W-1:0] depth_mm,
  input  logic                         q_full,
  output logic                         q_push,
  output dr2p_pkg::pix_t               q_item
);
  import dr2p_pkg::*;

  logic [CNT_W-1:0] col_count, col_count_next;
  logic [CNT_W-1:0] row_count, row_count_next;

  logic [CMP_W-1:0] col_x, row_x;
  logic [CMP_W-1:0] width_x, height_x;
  logic [CMP_W-1:0] last_col, last_row;
  logic [CMP_W:0]   diff_x, diff_y, negd_x, negd_y;
  logic             col_last, row_last, in_roi, depth_ok;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // Widen everything to one compare width
  assign col_x    = CMP_W'(col_count);
  assign row_x    = CMP_W'(row_count);
  assign width_x  = CMP_W'(geom.image_width);
  assign height_x = CMP_W'(geom.image_height);

  // A zero-sized axis counts as one
  assign last_col = (width_x == '0)  ? '0 : width_x - 1'b1;
  assign last_row = (height_x == '0) ? '0 : height_x - 1'b1;
  assign col_last = col_x >= last_col;
  assign row_last = row_x >= last_row;

  assign in_roi = (col_x >= CMP_W'(geom.roi_col_lo)) && (col_x <= CMP_W'(geom.roi_col_hi)) &&
                  (row_x >= CMP_W'(geom.roi_row_lo)) && (row_x <= CMP_W'(geom.roi_row_hi));
  assign depth_ok = (depth_mm != '0) &&
                    ({1'b0, depth_mm} < (DEPTH_W + 1)'(MAX_DEPTH_MM));

  // Signed offset from the frame centre, split into sign and magnitude
  assign diff_x = {1'b0, col_x} - {1'b0, width_x >> 1};
  assign diff_y = {1'b0, row_x} - {1'b0, height_x >> 1};
  assign negd_x = ~diff_x + 1'b1;
  assign negd_y = ~diff_y + 1'b1;

  always_comb begin
    q_item.keep      = in_roi && depth_ok;
    q_item.neg_x     = diff_x[CMP_W];
    q_item.mag_x     = diff_x[CMP_W] ? negd_x[CMP_W-1:0] : diff_x[CMP_W-1:0];
    q_item.neg_y     = diff_y[CMP_W];
    q_item.mag_y     = diff_y[CMP_W] ? negd_y[CMP_W-1:0] : diff_y[CMP_W-1:0];
    q_item.depth     = depth_mm;
    q_item.frame_end = col_last && row_last;
  end

  // Advance the counters, row is the inner loop
  always_comb begin
    col_count_next = col_count;
    row_count_next = row_count;
    if (row_last) begin
      row_count_next = '0;
      if (col_last) begin
        col_count_next = '0;
      end else if (col_count == CNT_W'(MAX_DIM - 1)) begin
        col_count_next = '0;
      end else begin
        col_count_next = col_count + 1'b1;
      end
    end else if (row_count == CNT_W'(MAX_DIM - 1)) begin
      row_count_next = '0;
    end else begin
      row_count_next = row_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (q_push) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

endmodule

### sv/dr2p_queue.sv
// Short first-in first-out queue of classified pixels.
module dr2p_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dr2p_pkg::pix_t push_item,
  output logic           full,
  input  logic           pop,
  output dr2p_pkg::pix_t pop_item,
  output logic           empty
);
  import dr2p_pkg::*;

  pix_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = count == QCNT_W'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_item = slots[rd_ptr];

  // Store the incoming transfer
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/dr2p_back.sv
// Back end: gain and depth multiplies, flooring, saturation, output register.
module dr2p_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [dr2p_pkg::GAIN_W-1:0]         x_gain,
  input  logic [dr2p_pkg::GAIN_W-1:0]         y_gain,
  input  logic                                q_empty,
  input  dr2p_pkg::pix_t                      q_item,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                point_valid,
  output logic signed [dr2p_pkg::COORD_W-1:0] point_x,
  output logic signed [dr2p_pkg::COORD_W-1:0] point_y,
  output logic [dr2p_pkg::Z_W-1:0]            point_z,
  output logic                                frame_end
);
  import dr2p_pkg::*;
  `include "depth_roi_to_point_macros.svh"

  localparam int CEIL_W = P2_W + 1 - FRAC_W;
  localparam int FLR_W  = P2_W - FRAC_W;

  logic advance;

  // Stage one: offset times gain
  logic               v1;
  pix_t               s1_item;
  logic [P1_W-1:0]    s1_px, s1_py;

  // Stage two: times depth
  logic               v2;
  pix_t               s2_item;
  logic [P2_W-1:0]    s2_mag_x, s2_mag_y;

  logic [COORD_W-1:0] x_sat, y_sat;
  logic [Z_W-1:0]     z_sat;

  // Whole pipe moves when the output register is free or being taken
  assign advance = !out_valid || out_ready;
  assign q_pop   = advance && !q_empty;

  // Floor the quotient toward minus infinity, then clamp
  function automatic logic [COORD_W-1:0] floor_sat(input logic neg, input logic [P2_W-1:0] mag);
    logic [P2_W:0]     bumped;
    logic [CEIL_W-1:0] ceil_q;
    logic [FLR_W-1:0]  flr_q;
    logic [COORD_W-1:0] res;
    bumped = {1'b0, mag} + (P2_W + 1)'((1 << FRAC_W) - 1);
    ceil_q = bumped[P2_W:FRAC_W];
    flr_q  = mag[P2_W-1:FRAC_W];
    if (neg) begin
      if (ceil_q > CEIL_W'(1 << (COORD_W - 1))) begin
        res = {1'b1, {(COORD_W - 1){1'b0}}};
      end else begin
        res = ~ceil_q[COORD_W-1:0] + 1'b1;
      end
    end else if (flr_q > FLR_W'((1 << (COORD_W - 1)) - 1)) begin
      res = {1'b0, {(COORD_W - 1){1'b1}}};
    end else begin
      res = flr_q[COORD_W-1:0];
    end
    return res;
  endfunction

  assign x_sat = floor_sat(s2_item.neg_x, s2_mag_x);
  assign y_sat = floor_sat(s2_item.neg_y, s2_mag_y);
  assign z_sat = (s2_item.depth > DEPTH_W'((1 << Z_W) - 1)) ? {Z_W{1'b1}} :
                 s2_item.depth[Z_W-1:0];

  // Payload stages
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_item  <= q_item;
      s1_px    <= P1_W'(q_item.mag_x * x_gain);
      s1_py    <= P1_W'(q_item.mag_y * y_gain);
      s2_item  <= s1_item;
      s2_mag_x <= P2_W'(s1_px * s1_item.depth);
      s2_mag_y <= P2_W'(s1_py * s1_item.depth);
      point_valid <= s2_item.keep;
      point_x     <= s2_item.keep ? x_sat : '0;
      point_y     <= s2_item.keep ? y_sat : '0;
      point_z     <= s2_item.keep ? z_sat : '0;
      frame_end   <= s2_item.frame_end;
    end
  end

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= q_pop;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  `DR2P_ASSERT_NOW(a_rejected_zero, out_valid && !point_valid, point_x == '0 && point_y == '0 && point_z == '0, "rejected pixel carries nonzero coordinates")
  `DR2P_ASSERT_NOW(a_kept_depth, out_valid && point_valid, point_z != '0, "kept pixel has zero depth")
  `DR2P_ASSERT_NEXT(a_stall_hold, v2 && out_valid && !out_ready, v2 && $stable(s2_mag_x) && $stable(s2_mag_y), "stage two moved during a stall")

endmodule

### sv/depth_roi_to_point.sv
// Top level of the depth-pixel to 3-D point unprojection block.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  input    | in_valid / in_ready    | depth_mm
//  output   | out_valid / out_ready  | point_valid point_x point_y point_z frame_end
//  config   | cfg_we                 | cfg_addr cfg_wdata
//
//  One pixel per clock is taken and one point per clock delivered when both sides flow.
//  From the queue a pixel passes the gain multiply, the depth multiply, and flooring
//  and saturation into the output register; a stalled output holds every stage.
//  The four-entry queue lets the counters keep taking pixels while the output stalls.
//  Synchronous reset restores the default geometry and gains and zeroes the counters.
module depth_roi_to_point (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [dr2p_pkg::REG_IDX_W-1:0]        cfg_addr,
  input  logic [dr2p_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [dr2p_pkg::DEPTH_W-1:0]          depth_mm,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  point_valid,
  output logic signed [dr2p_pkg::COORD_W-1:0]   point_x,
  output logic signed [dr2p_pkg::COORD_W-1:0]   point_y,
  output logic [dr2p_pkg::Z_W-1:0]              point_z,
  output logic                                  frame_end
);
  import dr2p_pkg::*;

  geom_t             geom;
  logic [GAIN_W-1:0] x_gain, y_gain;

  logic q_push, q_full, q_pop, q_empty;
  pix_t q_in, q_out;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      geom.image_width  <= DIM_W'(372);
      geom.image_height <= DIM_W'(198);
      geom.roi_col_lo   <= '0;
      geom.roi_col_hi   <= DIM_W'(371);
      geom.roi_row_lo   <= '0;
      geom.roi_row_hi   <= DIM_W'(197);
      x_gain            <= GAIN_W'(220);
      y_gain            <= GAIN_W'(248);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_IMAGE_WIDTH:  geom.image_width  <= cfg_wdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: geom.image_height <= cfg_wdata[DIM_W-1:0];
        REG_ROI_COL_LO:   geom.roi_col_lo   <= cfg_wdata[DIM_W-1:0];
        REG_ROI_COL_HI:   geom.roi_col_hi   <= cfg_wdata[DIM_W-1:0];
        REG_ROI_ROW_LO:   geom.roi_row_lo   <= cfg_wdata[DIM_W-1:0];
        REG_ROI_ROW_HI:   geom.roi_row_hi   <= cfg_wdata[DIM_W-1:0];
        REG_X_GAIN:       x_gain            <= cfg_wdata[GAIN_W-1:0];
        REG_Y_GAIN:       y_gain            <= cfg_wdata[GAIN_W-1:0];
      endcase
    end
  end

  dr2p_front u_front (
    .clk      (clk),
    .rst      (rst),
    .geom     (geom),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .depth_mm (depth_mm),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  dr2p_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out),
    .empty     (q_empty)
  );

  dr2p_back u_back (
    .clk         (clk),
    .rst         (rst),
    .x_gain      (x_gain),
    .y_gain      (y_gain),
    .q_empty     (q_empty),
    .q_item      (q_out),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .point_valid (point_valid),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .frame_end   (frame_end)
  );

endmodule
